FILE: rtl/cpu_alu_8bit_with_flags_unit_defines.svh
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_flags_unit_defines.svh
// Assertion macros for the ALU top-level RTL.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_8BIT_WITH_FLAGS_UNIT_DEFINES_SVH
`define CPU_ALU_8BIT_WITH_FLAGS_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/calu_pkg.sv
// ----------------------------------------------------------------------------
// calu_pkg
// Command codes, flag positions and word types for the 8-bit ALU.
// ----------------------------------------------------------------------------
package calu_pkg;

  localparam int unsigned CmdW = 4;

  localparam logic [CmdW-1:0] CMD_ADD   = 4'd0;
  localparam logic [CmdW-1:0] CMD_ADC   = 4'd1;
  localparam logic [CmdW-1:0] CMD_SUB   = 4'd2;
  localparam logic [CmdW-1:0] CMD_SBC   = 4'd3;
  localparam logic [CmdW-1:0] CMD_INC   = 4'd4;
  localparam logic [CmdW-1:0] CMD_DEC   = 4'd5;
  localparam logic [CmdW-1:0] CMD_AND   = 4'd6;
  localparam logic [CmdW-1:0] CMD_OR    = 4'd7;
  localparam logic [CmdW-1:0] CMD_XOR   = 4'd8;
  localparam logic [CmdW-1:0] CMD_ADD16 = 4'd9;

  localparam int unsigned FLAG_Z = 7;
  localparam int unsigned FLAG_N = 6;
  localparam int unsigned FLAG_H = 5;
  localparam int unsigned FLAG_C = 4;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [15:0]     first_operand;
    logic [15:0]     second_operand;
    logic [7:0]      flags_in;
  } req_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [7:0]  flags_out;
  } rsp_t;

endpackage

FILE: rtl/cpu_alu_8bit_with_flags_unit.sv
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_flags_unit
// 8-bit ALU with Z/N/H/C flag update and a 16-bit add, two register stages.
// ----------------------------------------------------------------------------
//
//  channel | signals                                            | role
//  --------+----------------------------------------------------+---------
//  in      | in_valid, in_ready, command, first_operand,        | command
//          | second_operand, flags_in                           | word
//  out     | out_valid, out_ready, result_value, flags_out      | result
//          |                                                    | word
//
// One word per cycle sustained while out_ready holds high. An accepted word
// enters the input register, which feeds the adder/flag logic, whose output
// lands in the result register and raises out_valid for the consumer.
// Reset (rst, synchronous) empties both stages; payload is not cleared.
// A stall on out_ready backs up stage by stage: both registers still fill,
// so two words are in flight before in_ready drops.
// ----------------------------------------------------------------------------
`include "cpu_alu_8bit_with_flags_unit_defines.svh"

module cpu_alu_8bit_with_flags_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic [15:0] first_operand,
  input  logic [15:0] second_operand,
  input  logic [7:0]  flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_value,
  output logic [7:0]  flags_out
);

  calu_pkg::req_t in_word;
  calu_pkg::req_t hold_word;
  calu_pkg::rsp_t core_rsp;
  calu_pkg::rsp_t out_word;
  logic           hold_valid;
  logic           hold_ready;

  // Pack the input ports into one command word.
  assign in_word.command        = command;
  assign in_word.first_operand  = first_operand;
  assign in_word.second_operand = second_operand;
  assign in_word.flags_in       = flags_in;

  // Stage 1: capture the command word.
  calu_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .hold_valid (hold_valid),
    .hold_ready (hold_ready),
    .hold_word  (hold_word)
  );

  // Compute result and new flags from the held word.
  calu_core u_core (
    .req (hold_word),
    .rsp (core_rsp)
  );

  // Stage 2: hold the result until the consumer takes it.
  calu_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .rsp_valid (hold_valid),
    .rsp_ready (hold_ready),
    .rsp_word  (core_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign result_value = out_word.result_value;
  assign flags_out    = out_word.flags_out;

  // An accepted word always occupies stage 1 on the next cycle.
  `CALU_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, hold_valid, "accepted word lost")
  // A word leaving stage 1 always shows up as a result.
  `CALU_ASSERT_NEXT(a_advance_fills, hold_valid && hold_ready, out_valid, "result word lost")
  // Low flag nibble passes through untouched.
  `CALU_ASSERT_NOW(a_low_flags, hold_valid,
                   core_rsp.flags_out[3:0] == hold_word.flags_in[3:0], "low flags altered")
  // 8-bit commands leave the upper result byte clear.
  `CALU_ASSERT_NOW(a_upper_zero, hold_valid && (hold_word.command <= calu_pkg::CMD_XOR),
                   core_rsp.result_value[15:8] == 8'd0, "upper byte set")

endmodule

FILE: rtl/calu_in_reg.sv
// ----------------------------------------------------------------------------
// calu_in_reg
// Input register: captures one command word, refills in the cycle it drains.
// ----------------------------------------------------------------------------
module calu_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  calu_pkg::req_t in_word,
  output logic          hold_valid,
  input  logic          hold_ready,
  output calu_pkg::req_t hold_word
);

  assign in_ready = !hold_valid || hold_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Payload needs no reset; load only on accept.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_word <= in_word;
    end
  end

endmodule

FILE: rtl/calu_core.sv
// ----------------------------------------------------------------------------
// calu_core
// Combinational datapath: adder, subtractor, logic ops and flag rules.
// ----------------------------------------------------------------------------
module calu_core (
  input  calu_pkg::req_t req,
  output calu_pkg::rsp_t rsp
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        c_add;
  logic        c_sub;
  logic [8:0]  sum8;
  logic [4:0]  half_sum;
  logic [8:0]  diff8;
  logic [4:0]  half_diff;
  logic [16:0] sum16;
  logic [12:0] half_sum16;
  logic [15:0] res;
  logic        z;
  logic        n;
  logic        h;
  logic        c;
  logic        eight;

  assign a8    = req.first_operand[7:0];
  assign b8    = req.second_operand[7:0];
  assign c_add = (req.command == calu_pkg::CMD_ADC) && req.flags_in[calu_pkg::FLAG_C];
  assign c_sub = (req.command == calu_pkg::CMD_SBC) && req.flags_in[calu_pkg::FLAG_C];

  assign sum8      = {1'b0, a8} + {1'b0, b8} + {8'd0, c_add};
  assign half_sum  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, c_add};
  // Top bit of a 9/5-bit difference is the borrow out.
  assign diff8     = {1'b0, a8} - {1'b0, b8} - {8'd0, c_sub};
  assign half_diff = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, c_sub};
  assign sum16      = {1'b0, req.first_operand} + {1'b0, req.second_operand};
  assign half_sum16 = {1'b0, req.first_operand[11:0]} + {1'b0, req.second_operand[11:0]};

  always_comb begin
    res   = req.first_operand;
    z     = req.flags_in[calu_pkg::FLAG_Z];
    n     = req.flags_in[calu_pkg::FLAG_N];
    h     = req.flags_in[calu_pkg::FLAG_H];
    c     = req.flags_in[calu_pkg::FLAG_C];
    eight = 1'b1;
    unique case (req.command) inside
      calu_pkg::CMD_ADD, calu_pkg::CMD_ADC: begin
        res = {8'd0, sum8[7:0]};
        n   = 1'b0;
        h   = half_sum[4];
        c   = sum8[8];
      end
      calu_pkg::CMD_SUB, calu_pkg::CMD_SBC: begin
        res = {8'd0, diff8[7:0]};
        n   = 1'b1;
        h   = half_diff[4];
        c   = diff8[8];
      end
      calu_pkg::CMD_INC: begin
        res = {8'd0, a8 + 8'd1};
        n   = 1'b0;
        h   = (a8[3:0] == 4'hF);
      end
      calu_pkg::CMD_DEC: begin
        res = {8'd0, a8 - 8'd1};
        n   = 1'b1;
        h   = (a8[3:0] == 4'h0);
      end
      calu_pkg::CMD_AND: begin
        res = {8'd0, a8 & b8};
        n   = 1'b0;
        h   = 1'b1;
        c   = 1'b0;
      end
      calu_pkg::CMD_OR: begin
        res = {8'd0, a8 | b8};
        n   = 1'b0;
        h   = 1'b0;
        c   = 1'b0;
      end
      calu_pkg::CMD_XOR: begin
        res = {8'd0, a8 ^ b8};
        n   = 1'b0;
        h   = 1'b0;
        c   = 1'b0;
      end
      calu_pkg::CMD_ADD16: begin
        eight = 1'b0;
        res   = sum16[15:0];
        n     = 1'b0;
        h     = half_sum16[12];
        c     = sum16[16];
      end
      default: begin
        // Unused codes: pass operand and flags through.
        eight = 1'b0;
      end
    endcase
    if (eight) begin
      z = (res[7:0] == 8'd0);
    end
  end

  assign rsp.result_value = res;
  assign rsp.flags_out    = {z, n, h, c, req.flags_in[3:0]};

endmodule

FILE: rtl/calu_out_reg.sv
// ----------------------------------------------------------------------------
// calu_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module calu_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          rsp_valid,
  output logic          rsp_ready,
  input  calu_pkg::rsp_t rsp_word,
  output logic          out_valid,
  input  logic          out_ready,
  output calu_pkg::rsp_t out_word
);

  assign rsp_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_ready) begin
      out_valid <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_word <= rsp_word;
    end
  end

endmodule
